// ===== design/pic_pkg.sv =====
// Shared types and constants for the clamped PI controller.
// Used by pic_csr, pic_ctrl, pic_dp and pi_controller_clamped; depends on nothing.
`default_nettype none

package pic_pkg;

   // Field and datapath widths
   localparam int GAIN_W    = 16;             // p_gain, i_gain
   localparam int SAMP_W    = 16;             // setpoint, measured
   localparam int ERR_W     = SAMP_W + 1;     // setpoint - measured
   localparam int PROD_W    = GAIN_W + ERR_W; // gain * error
   localparam int INTEG_W   = 48;             // integrator
   localparam int SUM_W     = INTEG_W + 1;    // pterm + integrator
   localparam int MAG_W     = SUM_W;          // magnitude of the sum, dividend
   localparam int QS_W      = MAG_W + 1;      // signed quotient
   localparam int DIV_W     = 16;             // scale_divisor
   localparam int OUT_W     = 32;             // control value and limits
   localparam int DIV_STEPS = MAG_W;          // one quotient bit per cycle
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int IDX_W  = 3;

   // Stream payloads
   localparam int REQ_DW = 32;
   localparam int RSP_DW = 32;

   typedef enum logic [IDX_W-1:0] {
      REG_P_GAIN        = 3'd0,
      REG_I_GAIN        = 3'd1,
      REG_SCALE_DIVISOR = 3'd2,
      REG_OUT_MAX       = 3'd3,
      REG_OUT_MIN       = 3'd4
   } reg_idx_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_MUL   = 10'b00_0000_0010,
      ST_INTEG = 10'b00_0000_0100,
      ST_SUM   = 10'b00_0000_1000,
      ST_ABS   = 10'b00_0001_0000,
      ST_DIV   = 10'b00_0010_0000,
      ST_FIX   = 10'b00_0100_0000,
      ST_CLAMP = 10'b00_1000_0000,
      ST_CLEAR = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] i_gain;
      logic [DIV_W-1:0]  scale_divisor;
      logic [OUT_W-1:0]  out_max;
      logic [OUT_W-1:0]  out_min;
   } cfg_type;

   typedef struct packed {
      logic load;      // capture the error of an accepted transaction
      logic mult;      // form both gain products
      logic integ;     // accumulate and saturate the integrator
      logic sum;       // add proportional term and integrator
      logic absval;    // take magnitude and start the divider
      logic div_step;  // one restoring division step
      logic fix;       // restore the quotient sign
      logic clamp;     // apply output limits
      logic clear;     // zero the integrator, repeat last output
      logic publish;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic div_last;  // the current division step is the final one
   } status_type;

endpackage

`default_nettype wire

// ===== design/pic_csr.sv =====
// Configuration register file of the clamped PI controller (APB-style port).
// Depends on pic_pkg.
`default_nettype none

module pic_csr (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [pic_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [pic_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [pic_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                   csr_pready,
   output      pic_pkg::cfg_type       cfg
);
   import pic_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              wr_en;
   logic [IDX_W-1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[CSR_AW-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_P_GAIN:        cfg_in.p_gain        = csr_pwdata[GAIN_W-1:0];
            REG_I_GAIN:        cfg_in.i_gain        = csr_pwdata[GAIN_W-1:0];
            REG_SCALE_DIVISOR: cfg_in.scale_divisor = csr_pwdata[DIV_W-1:0];
            REG_OUT_MAX:       cfg_in.out_max       = csr_pwdata[OUT_W-1:0];
            REG_OUT_MIN:       cfg_in.out_min       = csr_pwdata[OUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_P_GAIN:        csr_prdata = CSR_DW'(cfg_ff.p_gain);
         REG_I_GAIN:        csr_prdata = CSR_DW'(cfg_ff.i_gain);
         REG_SCALE_DIVISOR: csr_prdata = CSR_DW'(cfg_ff.scale_divisor);
         REG_OUT_MAX:       csr_prdata = CSR_DW'(cfg_ff.out_max);
         REG_OUT_MIN:       csr_prdata = CSR_DW'(cfg_ff.out_min);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain        <= GAIN_W'(256);
         cfg_ff.i_gain        <= '0;
         cfg_ff.scale_divisor <= DIV_W'(256);
         cfg_ff.out_max       <= OUT_W'(32767);
         cfg_ff.out_min       <= 32'hFFFF_8000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/pic_ctrl.sv =====
// Sequencing state machine of the clamped PI controller.
// Depends on pic_pkg; drives the datapath pic_dp through cmd_type commands.
`default_nettype none

module pic_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic                req_op,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire pic_pkg::status_type status,
   output      pic_pkg::cmd_type    cmd
);
   import pic_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_CLEAR) ? ST_CLEAR : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.absval = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

// ===== design/pic_dp.sv =====
// Arithmetic datapath of the clamped PI controller: products, saturating
// integrator, serial restoring divider, clamp and output register. Depends on pic_pkg.
`default_nettype none

module pic_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pic_pkg::cfg_type           cfg,
   input  wire pic_pkg::cmd_type           cmd,
   output      pic_pkg::status_type        status,
   input  wire logic [pic_pkg::SAMP_W-1:0] setpoint,
   input  wire logic [pic_pkg::SAMP_W-1:0] measured,
   output      logic [pic_pkg::OUT_W-1:0]  control_value,
   output      logic                       clamped
);
   import pic_pkg::*;

   // Payload registers
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [PROD_W-1:0]  pterm_ff, pterm_in;
   logic signed [PROD_W-1:0]  inc_ff, inc_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      neg_ff;
   logic [MAG_W-1:0]          dvd_ff, dvd_in;
   logic [DIV_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          dvsr_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [QS_W-1:0]    qs_ff, qs_in;
   logic [OUT_W-1:0]          result_ff;
   logic                      clip_ff;
   logic [OUT_W-1:0]          rsp_value_ff;
   logic                      rsp_clip_ff;

   // Control state
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic [OUT_W-1:0]          last_ff;

   logic signed [SUM_W-1:0]   integ_sum;
   logic signed [QS_W-1:0]    hi_ext, lo_ext;
   logic [DIV_W+1:0]          trial;
   logic [DIV_W:0]            shifted;
   logic                      qbit;

   assign err_in = $signed({setpoint[SAMP_W-1], setpoint})
                 - $signed({measured[SAMP_W-1], measured});

   assign pterm_in = $signed({{(PROD_W-GAIN_W){cfg.p_gain[GAIN_W-1]}}, cfg.p_gain})
                   * $signed({{(PROD_W-ERR_W){err_ff[ERR_W-1]}}, err_ff});
   assign inc_in   = $signed({{(PROD_W-GAIN_W){cfg.i_gain[GAIN_W-1]}}, cfg.i_gain})
                   * $signed({{(PROD_W-ERR_W){err_ff[ERR_W-1]}}, err_ff});

   // Integrator accumulation with saturation at the 48-bit signed range.
   assign integ_sum = $signed({integ_ff[INTEG_W-1], integ_ff})
                    + $signed({{(SUM_W-PROD_W){inc_ff[PROD_W-1]}}, inc_ff});

   always_comb begin
      if (integ_sum[SUM_W-1] != integ_sum[SUM_W-2]) begin
         integ_in = integ_sum[SUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   assign sum_in = $signed({{(SUM_W-PROD_W){pterm_ff[PROD_W-1]}}, pterm_ff})
                 + $signed({integ_ff[INTEG_W-1], integ_ff});

   // Restoring division step: one quotient bit per cycle.
   assign shifted = {rem_ff, dvd_ff[MAG_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvsr_ff};
   assign qbit    = ~trial[DIV_W+1];

   always_comb begin
      if (cmd.absval) begin
         dvd_in = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
         rem_in = '0;
      end else begin
         dvd_in = {dvd_ff[MAG_W-2:0], qbit};
         rem_in = qbit ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      end
   end

   assign status.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   assign qs_in  = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
   assign hi_ext = $signed({{(QS_W-OUT_W){cfg.out_max[OUT_W-1]}}, cfg.out_max});
   assign lo_ext = $signed({{(QS_W-OUT_W){cfg.out_min[OUT_W-1]}}, cfg.out_min});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= err_in;
      end
      if (cmd.mult) begin
         pterm_ff <= pterm_in;
         inc_ff   <= inc_in;
      end
      if (cmd.sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.absval) begin
         neg_ff  <= sum_ff[SUM_W-1];
         dvsr_ff <= (cfg.scale_divisor == '0) ? DIV_W'(1) : cfg.scale_divisor;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.absval || cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (cmd.fix) begin
         qs_ff <= qs_in;
      end
      if (cmd.clamp) begin
         if (qs_ff > hi_ext) begin
            result_ff <= cfg.out_max;
            clip_ff   <= 1'b1;
         end else if (qs_ff < lo_ext) begin
            result_ff <= cfg.out_min;
            clip_ff   <= 1'b1;
         end else begin
            result_ff <= qs_ff[OUT_W-1:0];
            clip_ff   <= 1'b0;
         end
      end else if (cmd.clear) begin
         result_ff <= last_ff;
         clip_ff   <= 1'b0;
      end
      if (cmd.publish) begin
         rsp_value_ff <= result_ff;
         rsp_clip_ff  <= clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         if (cmd.clear) begin
            integ_ff <= '0;
         end else if (cmd.integ) begin
            integ_ff <= integ_in;
         end
         if (cmd.clamp) begin
            if (qs_ff > hi_ext) begin
               last_ff <= cfg.out_max;
            end else if (qs_ff < lo_ext) begin
               last_ff <= cfg.out_min;
            end else begin
               last_ff <= qs_ff[OUT_W-1:0];
            end
         end
      end
   end

   assign control_value = rsp_value_ff;
   assign clamped       = rsp_clip_ff;

endmodule

`default_nettype wire

// ===== design/pi_controller_clamped.sv =====
// Top level of the clamped PI controller: stream ports, configuration port.
// Depends on pic_pkg, pic_csr, pic_ctrl and pic_dp.
`default_nettype none

// The block runs a proportional-integral control law on signed 16-bit
// samples. An update transaction (tuser 0) forms error = setpoint - measured,
// adds i_gain*error to a 48-bit integrator that saturates at its range, adds
// p_gain*error, divides the sum by scale_divisor with truncation toward zero
// (a divisor of zero acts as one), and clamps the quotient to out_max, then
// out_min, flagging a clamp in rsp_tuser. A clear transaction (tuser 1) zeroes
// the integrator and returns the previous control value unclamped. The block
// works on one transaction at a time: an update passes through the bit-serial
// restoring divider that produces one quotient bit per cycle before its result
// is presented. A new request is accepted once the result is moved to the
// output register, even while that result still waits for rsp_tready.
// Configuration registers (byte addresses 0x00 p_gain, 0x04 i_gain, 0x08
// scale_divisor, 0x0C out_max, 0x10 out_min) may be written only while the
// block is idle.

module pi_controller_clamped (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Request stream
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [pic_pkg::REQ_DW-1:0] req_tdata,  // [15:0] setpoint, [31:16] measured
   input  wire logic                       req_tuser,  // [0] op
   // Response stream
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [pic_pkg::RSP_DW-1:0] rsp_tdata,  // [31:0] control_value
   output      logic                       rsp_tuser,  // [0] clamped
   // Configuration port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [pic_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [pic_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [pic_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                       csr_pready
);
   import pic_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Register file; the user must hold values stable while a transaction is in flight (not enforced here).
   pic_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The sequencer owns the handshakes and steps the datapath.
   pic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the integrator, the divider and the output register.
   pic_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .setpoint      (req_tdata[SAMP_W-1:0]),
      .measured      (req_tdata[2*SAMP_W-1:SAMP_W]),
      .control_value (rsp_tdata),
      .clamped       (rsp_tuser)
   );

endmodule

`default_nettype wire
